>>> hdl/flptw_pkg.sv
package flptw_pkg;

   // Default geometry of the frame store and the walk
   localparam int unsigned DEFAULT_FRAMES = 64;
   localparam int unsigned DEFAULT_LEVELS = 5;

   // Address layout
   localparam int unsigned PAGE_SHIFT = 12;
   localparam int unsigned LEVEL_BITS = 9;
   localparam int unsigned ENTRIES_PER_TABLE = 1 << LEVEL_BITS;
   localparam int unsigned CANON_SHIFT = 56;
   localparam int unsigned CANON_W = 8;

   // Table entry: valid bit on top of a 52-bit page or frame number
   localparam int unsigned PAGE_W = 52;
   localparam int unsigned ENTRY_W = PAGE_W + 1;
   localparam int unsigned VALID_POS = PAGE_W;

   localparam int unsigned CFG_W = 7;
   localparam int unsigned ROOT_W = 20;
   localparam int unsigned VA_W = 64;

   // Request kinds
   localparam logic [1:0] KIND_QUERY = 2'd0;
   localparam logic [1:0] KIND_MAP = 2'd1;
   localparam logic [1:0] KIND_UNMAP = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // Result status codes
   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_NONCANON = 2'd1;
   localparam logic [1:0] STATUS_BAD_ROOT = 2'd2;
   localparam logic [1:0] STATUS_NO_FRAMES = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_FINISH
   } walk_state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [ROOT_W-1:0] root_frame;
      logic [VA_W-1:0] virtual_address;
      logic [PAGE_W-1:0] phys_page;
   } req_type;

   typedef struct packed {
      logic mapped;
      logic [PAGE_W-1:0] result_page;
      logic [1:0] status;
   } rsp_type;

endpackage

>>> hdl/flptw_store.sv
module flptw_store #(
   parameter int unsigned FRAMES = flptw_pkg::DEFAULT_FRAMES
) (
   input  logic clock,
   input  logic reset,
   input  logic mem_en,
   input  logic mem_we,
   input  logic [$clog2(FRAMES * flptw_pkg::ENTRIES_PER_TABLE)-1:0] mem_addr,
   input  logic [flptw_pkg::ENTRY_W-1:0] mem_wdata,
   output logic [flptw_pkg::ENTRY_W-1:0] mem_rdata,
   output logic busy
);

   localparam int unsigned DEPTH = FRAMES * flptw_pkg::ENTRIES_PER_TABLE;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic [flptw_pkg::ENTRY_W-1:0] mem [0:DEPTH-1];
   logic [flptw_pkg::ENTRY_W-1:0] rdata_ff;
   logic clear_busy_ff, clear_busy_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;

   // Sweep every entry to zero once after reset
   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_busy_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == LAST_ADDR) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         mem[clear_addr_ff] <= '0;
      end else if (mem_en) begin
         if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
         end else begin
            rdata_ff <= mem[mem_addr];
         end
      end
   end

   assign mem_rdata = rdata_ff;
   assign busy = clear_busy_ff;

endmodule

>>> hdl/five_level_page_table_walker.sv
// Flow: a request rejected up front goes from acceptance straight to the finish state; a full walk
// passes through a read state and then an evaluate state for each level on the single store port,
// then through the finish state.
// One request at a time: a new request is taken once the walk has finished, even while the
// previous response still waits on rsp_ready. Reset: synchronous; afterward the store is swept
// to zero with req_ready low. The allocator restarts at frame 1.
module five_level_page_table_walker #(
   parameter int unsigned FRAMES = flptw_pkg::DEFAULT_FRAMES,
   parameter int unsigned LEVELS = flptw_pkg::DEFAULT_LEVELS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  flptw_pkg::req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_ready,
   output flptw_pkg::rsp_type rsp_payload,
   input  logic csr_wr_en,
   input  logic [flptw_pkg::CFG_W-1:0] csr_wr_data
);

   localparam int unsigned FRAME_W = $clog2(FRAMES);
   localparam int unsigned ADDR_W = $clog2(FRAMES * flptw_pkg::ENTRIES_PER_TABLE);
   localparam int unsigned NF_BITS = $clog2(FRAMES + 1);
   localparam int unsigned NF_W = (NF_BITS > flptw_pkg::CFG_W) ? NF_BITS : flptw_pkg::CFG_W;
   localparam int unsigned LVL_W = $clog2(LEVELS);
   localparam logic [LVL_W-1:0] TOP_LEVEL = LVL_W'(LEVELS - 1);
   localparam logic [NF_W-1:0] FRAMES_NF = NF_W'(FRAMES);
   localparam logic [flptw_pkg::ROOT_W-1:0] FRAMES_ROOT = flptw_pkg::ROOT_W'(FRAMES);
   localparam logic [flptw_pkg::PAGE_W-1:0] FRAMES_PAGE = flptw_pkg::PAGE_W'(FRAMES);

   flptw_pkg::walk_state_type state_ff, state_in;

   // Latched request
   logic [1:0] kind_ff, kind_in;
   logic [flptw_pkg::VA_W-1:0] va_ff, va_in;
   logic [flptw_pkg::PAGE_W-1:0] ppn_ff, ppn_in;

   // Walk position
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [LVL_W-1:0] level_ff, level_in;

   // Bump allocator
   logic [NF_W-1:0] next_free_ff, next_free_in;

   // Finished result and output register
   flptw_pkg::rsp_type res_ff, res_in;
   flptw_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Store port
   logic mem_en, mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [flptw_pkg::ENTRY_W-1:0] mem_wdata, mem_rdata;
   logic store_busy;

   logic [flptw_pkg::LEVEL_BITS-1:0] level_idx;
   logic [flptw_pkg::CANON_W-1:0] req_top;
   logic entry_valid;
   logic [flptw_pkg::PAGE_W-1:0] entry_page;

   flptw_store #(
      .FRAMES(FRAMES)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .mem_en(mem_en),
      .mem_we(mem_we),
      .mem_addr(mem_addr),
      .mem_wdata(mem_wdata),
      .mem_rdata(mem_rdata),
      .busy(store_busy)
   );

   // Nine index bits of the current level; the slot address is frame:index
   assign level_idx = va_ff[flptw_pkg::PAGE_SHIFT + flptw_pkg::LEVEL_BITS * level_ff
                            +: flptw_pkg::LEVEL_BITS];
   assign mem_addr = {frame_ff, level_idx};

   assign req_top = req_payload.virtual_address[flptw_pkg::CANON_SHIFT +: flptw_pkg::CANON_W];
   assign entry_valid = mem_rdata[flptw_pkg::VALID_POS];
   assign entry_page = mem_rdata[flptw_pkg::PAGE_W-1:0];

   assign req_ready = (state_ff == flptw_pkg::ST_IDLE) && !store_busy;

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      va_in = va_ff;
      ppn_in = ppn_ff;
      frame_in = frame_ff;
      level_in = level_ff;
      next_free_in = next_free_ff;
      res_in = res_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_en = 1'b0;
      mem_we = 1'b0;
      mem_wdata = '0;

      // Drop the response once the consumer takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         flptw_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               kind_in = req_payload.kind;
               va_in = req_payload.virtual_address;
               ppn_in = req_payload.phys_page;
               frame_in = req_payload.root_frame[FRAME_W-1:0];
               level_in = TOP_LEVEL;
               res_in = '0;
               // Unused kind, address check, then root check
               priority if (req_payload.kind == flptw_pkg::KIND_UNUSED) begin
                  state_in = flptw_pkg::ST_FINISH;
               end else if (req_top != '0 && req_top != '1) begin
                  res_in.status = flptw_pkg::STATUS_NONCANON;
                  state_in = flptw_pkg::ST_FINISH;
               end else if (req_payload.root_frame == '0 ||
                            req_payload.root_frame >= FRAMES_ROOT) begin
                  res_in.status = flptw_pkg::STATUS_BAD_ROOT;
                  state_in = flptw_pkg::ST_FINISH;
               end else begin
                  state_in = flptw_pkg::ST_READ;
               end
            end
         end

         flptw_pkg::ST_READ: begin
            // Issue the read of the current level's slot
            mem_en = 1'b1;
            state_in = flptw_pkg::ST_EVAL;
         end

         flptw_pkg::ST_EVAL: begin
            if (level_ff == '0) begin
               // Leaf: report, write or clear the entry
               unique case (kind_ff)
                  flptw_pkg::KIND_QUERY: begin
                     res_in.mapped = entry_valid;
                     res_in.result_page = entry_valid ? entry_page : '0;
                  end
                  flptw_pkg::KIND_MAP: begin
                     mem_en = 1'b1;
                     mem_we = 1'b1;
                     mem_wdata = {1'b1, ppn_ff};
                  end
                  default: begin
                     mem_en = 1'b1;
                     mem_we = 1'b1;
                     mem_wdata = '0;
                  end
               endcase
               state_in = flptw_pkg::ST_FINISH;
            end else if (!entry_valid) begin
               priority if (kind_ff != flptw_pkg::KIND_MAP) begin
                  state_in = flptw_pkg::ST_FINISH;
               end else if (next_free_ff >= FRAMES_NF) begin
                  res_in.status = flptw_pkg::STATUS_NO_FRAMES;
                  state_in = flptw_pkg::ST_FINISH;
               end else begin
                  // Allocate a new table and point this slot at it
                  mem_en = 1'b1;
                  mem_we = 1'b1;
                  mem_wdata = {1'b1, flptw_pkg::PAGE_W'(next_free_ff)};
                  next_free_in = next_free_ff + 1'b1;
                  frame_in = next_free_ff[FRAME_W-1:0];
                  level_in = level_ff - 1'b1;
                  state_in = flptw_pkg::ST_READ;
               end
            end else if (entry_page >= FRAMES_PAGE) begin
               // Pointer outside the store ends the walk
               if (kind_ff != flptw_pkg::KIND_QUERY) begin
                  res_in.status = flptw_pkg::STATUS_BAD_ROOT;
               end
               state_in = flptw_pkg::ST_FINISH;
            end else begin
               frame_in = entry_page[FRAME_W-1:0];
               level_in = level_ff - 1'b1;
               state_in = flptw_pkg::ST_READ;
            end
         end

         flptw_pkg::ST_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = flptw_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = flptw_pkg::ST_IDLE;
         end
      endcase

      // A configuration write reloads the allocator
      if (csr_wr_en) begin
         next_free_in = NF_W'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= flptw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         next_free_ff <= NF_W'(1);
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         next_free_ff <= next_free_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      va_ff <= va_in;
      ppn_ff <= ppn_in;
      frame_ff <= frame_in;
      level_ff <= level_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
